// ===== design/tnh_pkg.sv =====
package tnh_pkg;

  // Fixed field widths
  localparam int RANK_W   = 10;
  localparam int CNT_W    = 6;
  localparam int POS_W    = RANK_W + 1;
  localparam int TDATA_W  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_RANK     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd2;

  // Divider: quotient bits resolved per pipeline stage
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = RANK_W / DIV_BITS_PER_STAGE;

  // One hop from x toward y on a ring of len positions, shorter way round,
  // direct way on a tie.
  function automatic logic [POS_W-1:0] ring_step(input logic [POS_W-1:0] x,
                                                 input logic [POS_W-1:0] y,
                                                 input logic [POS_W-1:0] len);
    logic [POS_W-1:0] d;
    logic [POS_W:0]   d2;
    logic             go_round;
    logic             up;
    logic [POS_W-1:0] nx;
    d        = (x > y) ? (x - y) : (y - x);
    d2       = {d, 1'b0};
    go_round = d2 > {1'b0, len};
    up       = (x > y) ? go_round : !go_round;
    if (up) begin
      nx = x + POS_W'(1);
    end else if (x == '0) begin
      nx = len - POS_W'(1);
    end else begin
      nx = x - POS_W'(1);
    end
    if (nx == len) begin
      nx = '0;
    end
    return nx;
  endfunction

endpackage

// ===== design/tnh_div.sv =====
// Pipelined restoring divider, two lanes sharing one divisor.
// Resolves DIV_BITS_PER_STAGE quotient bits per stage, one item per cycle while out_ready is high.
module tnh_div #(
  parameter int DIV_W = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [DIV_W-1:0]           divisor,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tnh_pkg::RANK_W-1:0] in_num_a,
  input  logic [tnh_pkg::RANK_W-1:0] in_num_b,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tnh_pkg::RANK_W-1:0] out_quo_a,
  output logic [DIV_W-1:0]           out_rem_a,
  output logic [tnh_pkg::RANK_W-1:0] out_quo_b,
  output logic [DIV_W-1:0]           out_rem_b
);
  import tnh_pkg::*;

  localparam int LANES  = 2;
  localparam int CHK_W  = RANK_W + DIV_W;

  logic [DIV_STAGES-1:0] valid_r;
  logic [DIV_STAGES:0]   rdy;
  logic [RANK_W-1:0]     num_r [DIV_STAGES][LANES];
  logic [RANK_W-1:0]     quo_r [DIV_STAGES][LANES];
  logic [DIV_W-1:0]      rem_r [DIV_STAGES][LANES];

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready        = rdy[0];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic              src_valid;
    logic [RANK_W-1:0] src_num [LANES];
    logic [RANK_W-1:0] src_quo [LANES];
    logic [DIV_W-1:0]  src_rem [LANES];
    logic [RANK_W-1:0] quo_nxt [LANES];
    logic [DIV_W-1:0]  rem_nxt [LANES];

    // stage input: port beat or previous stage
    if (k == 0) begin : g_first
      assign src_valid  = in_valid;
      assign src_num[0] = in_num_a;
      assign src_num[1] = in_num_b;
      assign src_quo[0] = '0;
      assign src_quo[1] = '0;
      assign src_rem[0] = '0;
      assign src_rem[1] = '0;
    end else begin : g_rest
      assign src_valid = valid_r[k-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign src_num[l] = num_r[k-1][l];
        assign src_quo[l] = quo_r[k-1][l];
        assign src_rem[l] = rem_r[k-1][l];
      end
    end

    // for each quotient bit of the stage: shift in one dividend bit, subtract if it fits
    always_comb begin
      logic [DIV_W:0] acc;
      for (int l = 0; l < LANES; l++) begin
        quo_nxt[l] = src_quo[l];
        acc        = {1'b0, src_rem[l]};
        for (int t = 0; t < DIV_BITS_PER_STAGE; t++) begin
          acc = {acc[DIV_W-1:0], src_num[l][RANK_W-1-(k*DIV_BITS_PER_STAGE+t)]};
          if (acc >= {1'b0, divisor}) begin
            acc = acc - {1'b0, divisor};
            quo_nxt[l][RANK_W-1-(k*DIV_BITS_PER_STAGE+t)] = 1'b1;
          end
        end
        rem_nxt[l] = acc[DIV_W-1:0];
      end
    end

    assign rdy[k] = !valid_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_r[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_valid) begin
        for (int l = 0; l < LANES; l++) begin
          num_r[k][l] <= src_num[l];
          quo_r[k][l] <= quo_nxt[l];
          rem_r[k][l] <= rem_nxt[l];
        end
      end
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_quo_a = quo_r[DIV_STAGES-1][0];
  assign out_rem_a = rem_r[DIV_STAGES-1][0];
  assign out_quo_b = quo_r[DIV_STAGES-1][1];
  assign out_rem_b = rem_r[DIV_STAGES-1][1];

  // remainders stay below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rem_a < divisor) && (out_rem_b < divisor))
    else $error("divider remainder not below divisor");

  // quotient and remainder rebuild the dividend
  a_rebuild_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CHK_W'(out_quo_a) * CHK_W'(divisor) + CHK_W'(out_rem_a))
                  == CHK_W'(num_r[DIV_STAGES-1][0]))
    else $error("divider lane a result inconsistent");

  a_rebuild_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CHK_W'(out_quo_b) * CHK_W'(divisor) + CHK_W'(out_rem_b))
                  == CHK_W'(num_r[DIV_STAGES-1][1]))
    else $error("divider lane b result inconsistent");

endmodule

// ===== design/torus_next_hop_router.sv =====
// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+--------------------------------------
// in_     | in  | in_tvalid/in_tready  | tdata[9:0] destination
// out_    | out | out_tvalid/out_tready| tdata[9:0] next_node, tuser arrived
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// One beat per cycle sustained while out_tready is high. Five divider stages
// split both node numbers into row and column (2 quotient bits each), one
// stage takes the ring steps, one forms the node number and holds the result.
// rst_n is synchronous; it empties the pipeline and loads own_rank 0,
// column_count 1, row_count 1. A stalled output backs up stage by stage;
// bubbles are squeezed out. cfg_ready is always high.
module torus_next_hop_router #(
  parameter int MAX_DIM = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tnh_pkg::TDATA_W-1:0]    in_tdata,   // [9:0] destination
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tnh_pkg::TDATA_W-1:0]    out_tdata,  // [9:0] next_node
  output logic                           out_tuser,  // [0] arrived
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tnh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tnh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tnh_pkg::*;

  localparam int CNT_EFF_W = $clog2(MAX_DIM + 1);
  localparam int PROD_W    = POS_W + CNT_EFF_W;

  // Configuration registers, counts stored already clamped
  logic [RANK_W-1:0]    own_rank_r;
  logic [CNT_EFF_W-1:0] cols_r;
  logic [CNT_EFF_W-1:0] rows_r;
  logic [CNT_EFF_W-1:0] cnt_eff;
  logic [CNT_W-1:0]     cnt_raw;

  assign cfg_ready = 1'b1;
  assign cnt_raw   = cfg_data[CNT_W-1:0];

  always_comb begin
    if (cnt_raw == '0) begin
      cnt_eff = CNT_EFF_W'(1);
    end else if (int'(cnt_raw) > MAX_DIM) begin
      cnt_eff = CNT_EFF_W'(MAX_DIM);
    end else begin
      cnt_eff = CNT_EFF_W'(cnt_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_rank_r <= '0;
      cols_r     <= CNT_EFF_W'(1);
      rows_r     <= CNT_EFF_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OWN_RANK:     own_rank_r <= cfg_data[RANK_W-1:0];
        CFG_COLUMN_COUNT: cols_r     <= cnt_eff;
        CFG_ROW_COUNT:    rows_r     <= cnt_eff;
        default:          ;
      endcase
    end
  end

  // Split own rank and destination into row/column
  logic                 div_valid;
  logic                 div_ready;
  logic [RANK_W-1:0]    my_row;
  logic [CNT_EFF_W-1:0] my_col;
  logic [RANK_W-1:0]    d_row;
  logic [CNT_EFF_W-1:0] d_col;

  tnh_div #(
    .DIV_W (CNT_EFF_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .divisor   (cols_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_num_a  (own_rank_r),
    .in_num_b  (in_tdata[RANK_W-1:0]),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_quo_a (my_row),
    .out_rem_a (my_col),
    .out_quo_b (d_row),
    .out_rem_b (d_col)
  );

  // Route stage: ring steps, pick row*cols + col operands
  logic             r1_valid_r;
  logic             r1_arrived_r;
  logic             r1_col_case_r;
  logic [POS_W-1:0] r1_mul_a_r;
  logic [POS_W-1:0] r1_add_b_r;
  logic             r1_arrived_nxt;
  logic             r1_col_case_nxt;
  logic [POS_W-1:0] r1_mul_a_nxt;
  logic [POS_W-1:0] r1_add_b_nxt;
  logic [POS_W-1:0] new_col;
  logic [POS_W-1:0] new_row;
  logic             r1_rdy;
  logic             out_rdy;

  assign new_col = ring_step(POS_W'(my_col), POS_W'(d_col), POS_W'(cols_r));
  assign new_row = ring_step(POS_W'(my_row), POS_W'(d_row), POS_W'(rows_r));

  assign r1_arrived_nxt  = (my_row == d_row) && (my_col == d_col);
  assign r1_col_case_nxt = my_col != d_col;
  assign r1_mul_a_nxt    = r1_col_case_nxt ? POS_W'(my_row) : new_row;
  assign r1_add_b_nxt    = r1_col_case_nxt ? new_col : POS_W'(my_col);

  assign r1_rdy    = !r1_valid_r || out_rdy;
  assign div_ready = r1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_valid_r <= 1'b0;
    end else if (r1_rdy) begin
      r1_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1_rdy && div_valid) begin
      r1_arrived_r  <= r1_arrived_nxt;
      r1_col_case_r <= r1_col_case_nxt;
      r1_mul_a_r    <= r1_mul_a_nxt;
      r1_add_b_r    <= r1_add_b_nxt;
    end
  end

  // Output stage: node number = row * cols + col, masked to rank width, zero for arrived beats
  logic              out_valid_r;
  logic              out_arrived_r;
  logic [RANK_W-1:0] out_node_r;
  logic [PROD_W-1:0] node_full;
  logic [RANK_W-1:0] out_node_nxt;

  assign node_full    = PROD_W'(r1_mul_a_r) * PROD_W'(cols_r) + PROD_W'(r1_add_b_r);
  assign out_node_nxt = r1_arrived_r ? '0 : node_full[RANK_W-1:0];
  assign out_rdy      = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= r1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && r1_valid_r) begin
      out_arrived_r <= r1_arrived_r;
      out_node_r    <= out_node_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_node_r);
  assign out_tuser  = out_arrived_r;

  // arrived beats carry node zero
  a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[RANK_W-1:0] == '0)
    else $error("arrived beat with nonzero next node");

  // a column hop stays inside the row
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    r1_valid_r && !r1_arrived_r && r1_col_case_r |-> r1_add_b_r < POS_W'(cols_r))
    else $error("column hop outside row");

  // a held result does not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_node_r)
                                   && $stable(out_arrived_r))
    else $error("output stage lost a stalled beat");

endmodule
